FILE: design/utf16_to_utf8_transcoder_defines.svh
// assertion helpers shared by the transcoder modules
`ifndef UTF16_TO_UTF8_TRANSCODER_DEFINES_SVH
`define UTF16_TO_UTF8_TRANSCODER_DEFINES_SVH

`ifndef SYNTHESIS
`define U16U8_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define U16U8_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define U16U8_ASSERT_NOW(label, clk, rstn, ante, cons)
`define U16U8_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

FILE: design/u16u8_pkg.sv
package u16u8_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [5:0] SURR_HIGH_TAG = 6'b110110;
    localparam logic [5:0] SURR_LOW_TAG  = 6'b110111;

    // byte count minus one of a code point
    localparam logic [1:0] LEN_1 = 2'd0;
    localparam logic [1:0] LEN_2 = 2'd1;
    localparam logic [1:0] LEN_3 = 2'd2;
    localparam logic [1:0] LEN_4 = 2'd3;

    // one job: an optional lone held high surrogate, then an optional code point
    typedef struct packed {
        logic        has_held;
        logic [9:0]  held_bits;
        logic        has_cp;
        logic [20:0] cp;
        logic [1:0]  cp_len;
        logic        last;
    } job_t;

    function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] len,
                                             input logic [1:0] idx);
        logic [7:0] b;
        b = {2'b10, cp[5:0]};
        unique case (len)
            LEN_1: b = cp[7:0];
            LEN_2: begin
                if (idx == 2'd0) b = {3'b110, cp[10:6]};
            end
            LEN_3: begin
                if (idx == 2'd0)      b = {4'b1110, cp[15:12]};
                else if (idx == 2'd1) b = {2'b10, cp[11:6]};
            end
            LEN_4: begin
                if (idx == 2'd0)      b = {5'b11110, cp[20:18]};
                else if (idx == 2'd1) b = {2'b10, cp[17:12]};
                else if (idx == 2'd2) b = {2'b10, cp[11:6]};
            end
            default: b = {2'b10, cp[5:0]};
        endcase
        return b;
    endfunction

endpackage

FILE: design/utf16_to_utf8_transcoder.sv
// UTF-16 to UTF-8 transcoder. Each transfer on s_ brings one 16-bit code unit plus an
// end-of-string flag; each transfer on m_ carries one UTF-8 byte, with m_run_last on the
// last byte produced for an input unit and m_string_last on the last byte of the string.
// A high surrogate that does not end the string is held until the next unit: a following
// low surrogate makes a 4-byte sequence, anything else sends the held surrogate out alone
// as 3 bytes. A unit that is only held yields no bytes; others yield up to 6, typically 1
// to 3. The front end takes one unit per cycle while its job queue (QUEUE_DEPTH entries)
// has room; the byte serializer behind it sends one byte per cycle while m_ready is high.
// A unit's first byte is registered after it passes the job queue and the job register.
module utf16_to_utf8_transcoder #(
    parameter int QUEUE_DEPTH = u16u8_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_code_unit,
    input  logic        s_text_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_run_last,
    output logic        m_string_last
);
    import u16u8_pkg::*;

    logic q_full;
    logic q_empty;
    logic push;
    logic pop;
    job_t push_job;
    job_t head_job;

    u16u8_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_code_unit (s_code_unit),
        .s_text_end  (s_text_end),
        .q_full      (q_full),
        .push        (push),
        .push_job    (push_job)
    );

    u16u8_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .full     (q_full),
        .empty    (q_empty)
    );

    u16u8_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_job      (head_job),
        .q_empty       (q_empty),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_run_last    (m_run_last),
        .m_string_last (m_string_last)
    );

endmodule

FILE: design/u16u8_queue.sv
`include "utf16_to_utf8_transcoder_defines.svh"

module u16u8_queue #(
    parameter int DEPTH = u16u8_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  u16u8_pkg::job_t push_job,
    input  logic            pop,
    output u16u8_pkg::job_t head_job,
    output logic            full,
    output logic            empty
);
    import u16u8_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_pop;

    assign full     = count_reg == CNT_W'(DEPTH);
    assign empty    = count_reg == '0;
    assign head_job = slot_reg[rd_ptr_reg];
    assign do_pop   = pop && !empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                slot_reg[wr_ptr_reg] <= push_job;
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (!push && do_pop) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `U16U8_ASSERT_NOW(a_no_push_when_full, aclk, aresetn, push, !full)
    `U16U8_ASSERT_NOW(a_count_in_range, aclk, aresetn, 1'b1, count_reg <= CNT_W'(DEPTH))

endmodule

FILE: design/u16u8_front.sv
`include "utf16_to_utf8_transcoder_defines.svh"

module u16u8_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [15:0]     s_code_unit,
    input  logic            s_text_end,
    input  logic            q_full,
    output logic            push,
    output u16u8_pkg::job_t push_job
);
    import u16u8_pkg::*;

    logic       held_valid_reg;
    logic       held_valid_next;
    logic [9:0] held_high_reg;
    logic [9:0] held_high_next;
    logic       accept;
    logic       is_high;
    logic       is_low;
    job_t       job;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign is_high = s_code_unit[15:10] == SURR_HIGH_TAG;
    assign is_low  = s_code_unit[15:10] == SURR_LOW_TAG;

    always_comb begin
        job             = '0;
        job.held_bits   = held_high_reg;
        job.last        = s_text_end;
        held_valid_next = held_valid_reg;
        held_high_next  = held_high_reg;
        if (held_valid_reg && is_low) begin
            // surrogate pair -> supplementary code point
            job.has_cp      = 1'b1;
            job.cp          = 21'({held_high_reg, s_code_unit[9:0]}) + 21'h10000;
            job.cp_len      = LEN_4;
            held_valid_next = 1'b0;
            held_high_next  = '0;
        end else begin
            job.has_held    = held_valid_reg;
            held_valid_next = 1'b0;
            held_high_next  = '0;
            if (is_high && !s_text_end) begin
                held_valid_next = 1'b1;
                held_high_next  = s_code_unit[9:0];
            end else begin
                job.has_cp = 1'b1;
                job.cp     = 21'(s_code_unit);
                if (s_code_unit < 16'h0080)      job.cp_len = LEN_1;
                else if (s_code_unit < 16'h0800) job.cp_len = LEN_2;
                else                             job.cp_len = LEN_3;
            end
        end
    end

    assign push     = accept && (job.has_held || job.has_cp);
    assign push_job = job;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_valid_reg <= 1'b0;
            held_high_reg  <= '0;
        end else if (accept) begin
            held_valid_reg <= held_valid_next;
            held_high_reg  <= held_high_next;
        end
    end

    `U16U8_ASSERT_NEXT(a_nothing_held_after_end, aclk, aresetn, accept && s_text_end,
        !held_valid_reg)

endmodule

FILE: design/u16u8_back.sv
`include "utf16_to_utf8_transcoder_defines.svh"

module u16u8_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  u16u8_pkg::job_t head_job,
    input  logic            q_empty,
    output logic            pop,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [7:0]      m_out_byte,
    output logic            m_run_last,
    output logic            m_string_last
);
    import u16u8_pkg::*;

    job_t        cur_job_reg;
    logic        cur_valid_reg;
    logic        in_held_reg;
    logic [1:0]  idx_reg;
    logic        m_valid_reg;
    logic [7:0]  m_out_byte_reg;
    logic        m_run_last_reg;
    logic        m_string_last_reg;

    logic        advance;
    logic [20:0] seg_cp;
    logic [1:0]  seg_len;
    logic        seg_end;
    logic        final_seg;
    logic        load;

    always_comb begin
        advance   = cur_valid_reg && (!m_valid_reg || m_ready);
        seg_cp    = in_held_reg ? 21'({SURR_HIGH_TAG, cur_job_reg.held_bits}) : cur_job_reg.cp;
        seg_len   = in_held_reg ? LEN_3 : cur_job_reg.cp_len;
        seg_end   = idx_reg == seg_len;
        final_seg = seg_end && (!in_held_reg || !cur_job_reg.has_cp);
        load      = (!cur_valid_reg || (advance && final_seg)) && !q_empty;
    end

    assign pop = load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            in_held_reg   <= 1'b0;
            idx_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (advance) begin
                m_valid_reg       <= 1'b1;
                m_out_byte_reg    <= utf8_byte(seg_cp, seg_len, idx_reg);
                m_run_last_reg    <= final_seg;
                m_string_last_reg <= final_seg && cur_job_reg.last;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            if (load) begin
                cur_job_reg   <= head_job;
                cur_valid_reg <= 1'b1;
                in_held_reg   <= head_job.has_held;
                idx_reg       <= '0;
            end else if (advance) begin
                if (final_seg) begin
                    cur_valid_reg <= 1'b0;
                end else if (seg_end) begin
                    // lone surrogate done, move on to the unit's own code point
                    in_held_reg <= 1'b0;
                    idx_reg     <= '0;
                end else begin
                    idx_reg <= idx_reg + 2'd1;
                end
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_byte    = m_out_byte_reg;
    assign m_run_last    = m_run_last_reg;
    assign m_string_last = m_string_last_reg;

    `U16U8_ASSERT_NOW(a_string_last_ends_run, aclk, aresetn, m_valid_reg && m_string_last_reg,
        m_run_last_reg)
    `U16U8_ASSERT_NOW(a_held_seg_has_held, aclk, aresetn, cur_valid_reg && in_held_reg,
        cur_job_reg.has_held)
    `U16U8_ASSERT_NOW(a_idx_in_seg, aclk, aresetn, cur_valid_reg, idx_reg <= seg_len)

endmodule

FILE: tb/sv/utf16_to_utf8_checker.sv
module utf16_to_utf8_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [15:0] s_code_unit,
    input  logic        s_text_end,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_out_byte,
    input  logic        m_run_last,
    input  logic        m_string_last,
    output int          mismatches,
    output int          bytes_due
);
    timeunit 1ns;
    timeprecision 1ps;

    import u16u8_pkg::*;

    localparam logic [20:0] SUPP_BASE    = 21'h10000;
    localparam logic [20:0] TWO_BYTE_MIN = 21'h80;
    localparam logic [20:0] THR_BYTE_MIN = 21'h800;
    localparam logic [20:0] FOUR_BYTE_MIN = 21'h10000;
    localparam logic [7:0]  LEAD_2       = 8'hC0;
    localparam logic [7:0]  LEAD_3       = 8'hE0;
    localparam logic [7:0]  LEAD_4       = 8'hF0;
    localparam logic [7:0]  CONT         = 8'h80;

    typedef struct packed {
        logic [7:0] value;
        logic       run_last;
        logic       string_last;
    } utf8_byte_t;

    utf8_byte_t utf8_expected[$];
    logic [7:0] unit_bytes[$];
    logic [9:0] held_bits = '0;
    logic       held_valid = 1'b0;
    int         fail_count = 0;

    function void add_byte(input logic [7:0] b);
        unit_bytes.insert(unit_bytes.size(), b);
    endfunction

    function void add_expected(input utf8_byte_t e);
        utf8_expected.insert(utf8_expected.size(), e);
    endfunction

    function void encode_code_point(input logic [20:0] cp);
        if (cp < TWO_BYTE_MIN) begin
            add_byte(cp[7:0]);
        end else if (cp < THR_BYTE_MIN) begin
            add_byte(LEAD_2 | {3'b000, cp[10:6]});
            add_byte(CONT | {2'b00, cp[5:0]});
        end else if (cp < FOUR_BYTE_MIN) begin
            add_byte(LEAD_3 | {4'b0000, cp[15:12]});
            add_byte(CONT | {2'b00, cp[11:6]});
            add_byte(CONT | {2'b00, cp[5:0]});
        end else begin
            add_byte(LEAD_4 | {5'b00000, cp[20:18]});
            add_byte(CONT | {2'b00, cp[17:12]});
            add_byte(CONT | {2'b00, cp[11:6]});
            add_byte(CONT | {2'b00, cp[5:0]});
        end
    endfunction

    // bytes that one accepted code unit releases, queued in output order
    function void transcode_unit(input logic [15:0] cu, input logic text_end);
        logic       is_high;
        logic       is_low;
        utf8_byte_t entry;
        is_high = (cu[15:10] == SURR_HIGH_TAG);
        is_low  = (cu[15:10] == SURR_LOW_TAG);
        unit_bytes.delete();
        if (held_valid && is_low) begin
            encode_code_point(SUPP_BASE + {1'b0, held_bits, cu[9:0]});
            held_valid = 1'b0;
            held_bits  = '0;
        end else begin
            // lone high surrogate goes out first as its own 3-byte sequence
            if (held_valid) begin
                encode_code_point({5'd0, SURR_HIGH_TAG, held_bits});
                held_valid = 1'b0;
                held_bits  = '0;
            end
            if (is_high && !text_end) begin
                held_bits  = cu[9:0];
                held_valid = 1'b1;
            end else begin
                encode_code_point({5'd0, cu});
            end
        end
        foreach (unit_bytes[i]) begin
            entry.value       = unit_bytes[i];
            entry.run_last    = (i == unit_bytes.size() - 1);
            entry.string_last = (i == unit_bytes.size() - 1) && text_end;
            add_expected(entry);
        end
    endfunction

    always @(posedge aclk) begin : watch_channels
        utf8_byte_t want;
        if (!aresetn) begin
            held_valid = 1'b0;
            held_bits  = '0;
            utf8_expected.delete();
        end else begin
            if (s_valid && s_ready) begin
                transcode_unit(s_code_unit, s_text_end);
            end
            if (m_valid && m_ready) begin
                if (utf8_expected.size() == 0) begin
                    fail_count++;
                    $display("%0t: byte transfer with nothing expected: expected none, actual %h",
                             $time, m_out_byte);
                end else begin
                    want = utf8_expected.pop_front();
                    if (m_out_byte !== want.value) begin
                        fail_count++;
                        $display("%0t: out_byte expected %h actual %h",
                                 $time, want.value, m_out_byte);
                    end
                    if (m_run_last !== want.run_last) begin
                        fail_count++;
                        $display("%0t: run_last expected %b actual %b",
                                 $time, want.run_last, m_run_last);
                    end
                    if (m_string_last !== want.string_last) begin
                        fail_count++;
                        $display("%0t: string_last expected %b actual %b",
                                 $time, want.string_last, m_string_last);
                    end
                end
            end
        end
        mismatches <= fail_count;
        bytes_due  <= utf8_expected.size();
    end

endmodule

FILE: tb/sv/tb_utf16_to_utf8_transcoder.sv
module tb_utf16_to_utf8_transcoder;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD      = 6;
    localparam int MAX_GAP          = 17;
    localparam int TOTAL_UNITS      = 250;
    localparam int LONG_HOLD_AFTER  = 150;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES     = 20;
    localparam int TIMEOUT_CYCLES   = 250000;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_valid       = 1'b0;
    logic [15:0] s_code_unit   = '0;
    logic        s_text_end    = 1'b0;
    logic        m_ready       = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic [7:0]  m_out_byte;
    logic        m_run_last;
    logic        m_string_last;

    int   mismatches;
    int   bytes_due;
    int   units_sent = 0;
    logic tx_burst   = 1'b0;
    logic rx_burst   = 1'b0;
    logic rx_hold    = 1'b0;

    always #HALF_PERIOD aclk = ~aclk;

    utf16_to_utf8_transcoder i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_code_unit   (s_code_unit),
        .s_text_end    (s_text_end),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_run_last    (m_run_last),
        .m_string_last (m_string_last)
    );

    utf16_to_utf8_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_code_unit   (s_code_unit),
        .s_text_end    (s_text_end),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_run_last    (m_run_last),
        .m_string_last (m_string_last),
        .mismatches    (mismatches),
        .bytes_due     (bytes_due)
    );

    task automatic send_unit(input logic [15:0] cu, input logic text_end);
        int gap;
        gap = (tx_burst || rx_hold) ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_code_unit <= cu;
        s_text_end  <= text_end;
        do @(posedge aclk); while (!s_ready);
        units_sent++;
    endtask

    // stop offering until every predicted byte has been taken
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        wait (bytes_due == 0);
        @(posedge aclk);
    endtask

    initial begin : stimulus
        int          str_len;
        int          pick;
        bit          paused;
        logic        is_last;
        logic [15:0] cu;
        paused = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // range edges of each sequence length
        send_unit(16'h0000, 1'b0);
        send_unit(16'h007F, 1'b0);
        send_unit(16'h0080, 1'b0);
        send_unit(16'h07FF, 1'b0);
        send_unit(16'h0800, 1'b0);
        send_unit(16'hD7FF, 1'b0);
        send_unit(16'hE000, 1'b0);
        send_unit(16'hFFFF, 1'b1);
        // lowest and highest surrogate pairs
        send_unit(16'hD800, 1'b0);
        send_unit(16'hDC00, 1'b0);
        send_unit(16'hDBFF, 1'b0);
        send_unit(16'hDFFF, 1'b1);
        // unpaired low surrogates
        send_unit(16'hDC00, 1'b0);
        send_unit(16'hDFFF, 1'b0);
        // held high flushed by a plain unit
        send_unit(16'hD812, 1'b0);
        send_unit(16'h0041, 1'b0);
        // high over high, the second one then pairs
        send_unit(16'hD801, 1'b0);
        send_unit(16'hDBFE, 1'b0);
        send_unit(16'hDC05, 1'b0);
        // high surrogate ending the string
        send_unit(16'hDABC, 1'b1);
        // held high followed by a 3-byte or a 2-byte unit at string end
        send_unit(16'hD900, 1'b0);
        send_unit(16'h4E2D, 1'b1);
        send_unit(16'hD834, 1'b0);
        send_unit(16'h07FF, 1'b1);
        wait_for_drain();

        while (units_sent < TOTAL_UNITS) begin
            tx_burst = ($urandom_range(0, 3) == 0);
            str_len  = $urandom_range(1, 12);
            for (int i = 0; i < str_len; i++) begin
                is_last = (i == str_len - 1);
                pick    = $urandom_range(0, 9);
                if (pick <= 2) begin
                    send_unit(16'($urandom_range(0, 16'h007F)), is_last);
                end else if (pick == 3) begin
                    send_unit(16'($urandom_range(16'h0080, 16'h07FF)), is_last);
                end else if (pick <= 5) begin
                    cu = 16'($urandom_range(16'h0800, 16'hFFFF));
                    // move surrogates out of the way to keep a plain BMP unit
                    if (cu >= 16'hD800 && cu <= 16'hDFFF) cu = cu ^ 16'h2000;
                    send_unit(cu, is_last);
                end else if (pick <= 7) begin
                    send_unit(16'($urandom_range(16'hD800, 16'hDBFF)), 1'b0);
                    send_unit(16'($urandom_range(16'hDC00, 16'hDFFF)), is_last);
                end else if (pick == 8) begin
                    send_unit(16'($urandom_range(0, 16'hFFFF)), is_last);
                end else begin
                    send_unit(16'($urandom_range(16'hD800, 16'hDFFF)), is_last);
                end
            end
            if (!paused && units_sent >= TOTAL_UNITS / 2) begin
                paused = 1'b1;
                wait_for_drain();
            end
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        wait (bytes_due == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && bytes_due == 0) begin
            $display("tb_utf16_to_utf8_transcoder: clean");
        end else begin
            $display("tb_utf16_to_utf8_transcoder: errors");
        end
        $finish;
    end

    initial begin : byte_sink
        int gap;
        int taken;
        taken = 0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (taken % 16 == 0) rx_burst = ($urandom_range(0, 3) == 0);
            if (taken == LONG_HOLD_AFTER) begin
                // long back-pressure so the job queue fills and s_ready drops
                gap     = LONG_HOLD_CYCLES;
                rx_hold = 1'b1;
            end else begin
                gap = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            rx_hold = 1'b0;
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            taken++;
        end
    end

    initial begin : watchdog
        #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
        $display("tb_utf16_to_utf8_transcoder: errors");
        $finish;
    end

endmodule

FILE: utf16_to_utf8_transcoder.f
+incdir+design
design/u16u8_pkg.sv
design/u16u8_queue.sv
design/u16u8_front.sv
design/u16u8_back.sv
design/utf16_to_utf8_transcoder.sv
tb/sv/utf16_to_utf8_checker.sv
tb/sv/tb_utf16_to_utf8_transcoder.sv
